>>> rtl/delta_list_timer_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta list timer queue checker.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DLTQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dltq: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define DLTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dltq: next-cycle check failed");

`endif

>>> rtl/dltq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_pkg
// Types and constants shared by the delta list timer queue modules.
// ----------------------------------------------------------------------------
package dltq_pkg;

    // Width in bits of a delta or an interval, which count ticks.
    localparam int DELTA_W = 16;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // One input transaction.
    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         tmr_sel;
        logic [DELTA_W-1:0] interval;
        logic               repeat_req;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic       expired_valid;
        logic [3:0] expired_id;
        logic       accepted;
        logic       last;
    } t_out_item;

    // Source of the node memory read address.
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NODE,
        RD_LINKQ
    } t_rd_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;
        logic    start_setup;
        logic    reload_setup;
        logic    stop_setup;
        logic    tick_dec;
        logic    pop;
        logic    walk_step;
        logic    walk_split;
        logic    link_fin;
        logic    link_prev;
        logic    unl_step;
        logic    unl_found;
        logic    unl_add;
        logic    emit;
        logic    emit_exp;
        logic    emit_acc;
        logic    emit_last;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       id_ok;
        logic       id_running;
        logic       head_nil;
        logic       link_nil;
        logic       prev_nil;
        logic       node_is_t;
        logic       delta_le;
        logic       dec_zero;
        logic       delta_nz;
        logic       node_repeat;
        logic       out_free;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/dltq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_datapath
// Node memories, list pointers, walk registers and the result register.
// ----------------------------------------------------------------------------
module dltq_datapath #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dltq_pkg::t_in_item   i_in_item,
    input  wire dltq_pkg::t_dp_cmd    i_cmd,
    output dltq_pkg::t_dp_status      o_status,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output dltq_pkg::t_out_item       o_out_item
);

    localparam int AW = $clog2(NUM_TIMERS);
    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);
    localparam int DW = dltq_pkg::DELTA_W;

    // Node memories: delta over predecessor, successor link, reload interval.
    logic [DW-1:0] delta_mem  [NUM_TIMERS];
    logic [LW-1:0] link_mem   [NUM_TIMERS];
    logic [DW-1:0] reload_mem [NUM_TIMERS];

    logic [DW-1:0] r_delta_q;
    logic [LW-1:0] r_link_q;
    logic [DW-1:0] r_reload_q;

    logic [LW-1:0] r_head;
    logic [LW-1:0] r_node;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_t;
    logic [DW-1:0] r_rem;
    logic [1:0]    r_op;
    logic [3:0]    r_id;
    logic [DW-1:0] r_ival;
    logic          r_rep;

    logic [NUM_TIMERS-1:0] r_running;
    logic [NUM_TIMERS-1:0] r_repeat;

    logic                r_out_valid;
    dltq_pkg::t_out_item r_out_item;

    logic [LW-1:0] rd_addr;
    logic [AW-1:0] id_idx;
    logic          id_ok;
    logic          dw_en;
    logic [LW-1:0] dw_addr;
    logic [DW-1:0] dw_data;
    logic          lw_en;
    logic [LW-1:0] lw_addr;
    logic [LW-1:0] lw_data;
    logic [DW-1:0] dec_delta;

    assign id_ok     = (32'(r_id) < NUM_TIMERS);
    assign id_idx    = AW'(r_id);
    assign dec_delta = (r_delta_q != '0) ? (r_delta_q - 1'b1) : '0;

    // Read address select; all three memories read the same node.
    always_comb begin
        case (i_cmd.rd_sel)
            dltq_pkg::RD_NODE:  rd_addr = r_node;
            dltq_pkg::RD_LINKQ: rd_addr = r_link_q;
            default:            rd_addr = r_head;
        endcase
    end

    // Delta memory write port.
    always_comb begin
        dw_en   = 1'b0;
        dw_addr = r_head;
        dw_data = dec_delta;
        if (i_cmd.tick_dec) begin
            dw_en = 1'b1;
        end else if (i_cmd.walk_split) begin
            dw_en   = 1'b1;
            dw_addr = r_node;
            dw_data = r_delta_q - r_rem;
        end else if (i_cmd.link_fin) begin
            dw_en   = 1'b1;
            dw_addr = r_t;
            dw_data = r_rem;
        end else if (i_cmd.unl_add) begin
            dw_en   = 1'b1;
            dw_addr = r_node;
            dw_data = r_delta_q + r_rem;
        end
    end

    // Link memory write port.
    always_comb begin
        lw_en   = 1'b0;
        lw_addr = r_t;
        lw_data = r_node;
        if (i_cmd.link_fin) begin
            lw_en = 1'b1;
        end else if (i_cmd.link_prev) begin
            lw_en   = 1'b1;
            lw_addr = r_prev;
            lw_data = r_t;
        end else if (i_cmd.unl_found && (r_prev != NIL)) begin
            lw_en   = 1'b1;
            lw_addr = r_prev;
            lw_data = r_link_q;
        end
    end

    // Memory reads, registered.
    always_ff @(posedge i_clk) begin
        r_delta_q  <= delta_mem[rd_addr[AW-1:0]];
        r_link_q   <= link_mem[rd_addr[AW-1:0]];
        r_reload_q <= reload_mem[rd_addr[AW-1:0]];
    end

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (dw_en) begin
            delta_mem[dw_addr[AW-1:0]] <= dw_data;
        end
        if (lw_en) begin
            link_mem[lw_addr[AW-1:0]] <= lw_data;
        end
        if (i_cmd.start_setup) begin
            reload_mem[id_idx] <= r_ival;
        end
    end

    // List head, timer flags and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NIL;
            r_running   <= '0;
            r_repeat    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pop) begin
                r_head <= r_link_q;
                r_running[r_head[AW-1:0]] <= 1'b0;
            end
            if (i_cmd.link_fin) begin
                r_running[r_t[AW-1:0]] <= 1'b1;
                if (r_prev == NIL) begin
                    r_head <= r_t;
                end
            end
            if (i_cmd.unl_found) begin
                r_running[r_t[AW-1:0]] <= 1'b0;
                if (r_prev == NIL) begin
                    r_head <= r_link_q;
                end
            end
            if (i_cmd.start_setup) begin
                r_repeat[id_idx] <= r_rep;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured transaction, walk registers and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_in_item.op;
            r_id   <= i_in_item.tmr_sel;
            r_ival <= (i_in_item.interval == '0) ? DW'(1) : i_in_item.interval;
            r_rep  <= i_in_item.repeat_req;
        end
        if (i_cmd.start_setup) begin
            r_t    <= LW'(r_id);
            r_rem  <= r_ival;
            r_node <= r_head;
            r_prev <= NIL;
        end else if (i_cmd.reload_setup) begin
            r_t    <= r_node;
            r_rem  <= (r_reload_q == '0) ? DW'(1) : r_reload_q;
            r_node <= r_head;
            r_prev <= NIL;
        end else if (i_cmd.stop_setup) begin
            r_t    <= LW'(r_id);
            r_node <= r_head;
            r_prev <= NIL;
        end else if (i_cmd.walk_step) begin
            r_rem  <= r_rem - r_delta_q;
            r_prev <= r_node;
            r_node <= r_link_q;
        end else if (i_cmd.unl_step) begin
            r_prev <= r_node;
            r_node <= r_link_q;
        end else if (i_cmd.unl_found) begin
            r_rem  <= r_delta_q;
            r_node <= r_link_q;
        end else if (i_cmd.pop) begin
            r_node <= r_head;
        end
        if (i_cmd.emit) begin
            r_out_item.expired_valid <= i_cmd.emit_exp;
            r_out_item.expired_id    <= i_cmd.emit_exp ? 4'(r_node) : 4'd0;
            r_out_item.accepted      <= i_cmd.emit_acc;
            r_out_item.last          <= i_cmd.emit_last;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.op          = r_op;
        o_status.id_ok       = id_ok;
        o_status.id_running  = id_ok && r_running[id_idx];
        o_status.head_nil    = (r_head == NIL);
        o_status.link_nil    = (r_link_q == NIL);
        o_status.prev_nil    = (r_prev == NIL);
        o_status.node_is_t   = (r_node == r_t);
        o_status.delta_le    = (r_delta_q <= r_rem);
        o_status.dec_zero    = (r_delta_q <= DW'(1));
        o_status.delta_nz    = (r_delta_q != '0);
        o_status.node_repeat = r_repeat[r_node[AW-1:0]];
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

>>> rtl/dltq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for ticks, sorted inserts and unlinks over the delta list.
// ----------------------------------------------------------------------------
module dltq_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire dltq_pkg::t_dp_status i_status,
    output dltq_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RESP,
        S_TICK_DEC,
        S_POP_RD,
        S_POP_HEAD,
        S_POP_CHK,
        S_POP_EMIT,
        S_RELOAD_GO,
        S_LINK_WALK,
        S_LINK_FIN,
        S_LINK_PREV,
        S_UNL_WALK,
        S_UNL_ADD
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state done_state;
    logic   r_acc;
    logic   n_acc;
    logic   r_last;
    logic   n_last;
    logic   r_in_tick;
    logic   n_in_tick;

    assign o_in_ready = (r_state == S_IDLE);

    // Where an insert goes when it is linked: back to popping, to idle after the last expiry, or to the response.
    always_comb begin
        if (r_in_tick) begin
            done_state = r_last ? S_IDLE : S_POP_RD;
        end else begin
            done_state = S_RESP;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_last    = r_last;
        n_in_tick = r_in_tick;
        o_cmd        = '0;
        o_cmd.rd_sel = dltq_pkg::RD_HEAD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_acc = 1'b0;
                case (i_status.op)
                    dltq_pkg::OP_TICK: begin
                        if (i_status.head_nil) begin
                            n_state = S_RESP;
                        end else begin
                            n_in_tick = 1'b1;
                            n_state   = S_TICK_DEC;
                        end
                    end
                    dltq_pkg::OP_START: begin
                        if (i_status.id_ok && !i_status.id_running) begin
                            o_cmd.start_setup = 1'b1;
                            n_in_tick         = 1'b0;
                            n_state = i_status.head_nil ? S_LINK_FIN : S_LINK_WALK;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    dltq_pkg::OP_STOP: begin
                        if (i_status.id_ok && i_status.id_running) begin
                            o_cmd.stop_setup = 1'b1;
                            n_state          = S_UNL_WALK;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_acc  = r_acc;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_TICK_DEC: begin
                // Head data is at hand: decrement, and pop when it reaches zero.
                o_cmd.tick_dec = 1'b1;
                if (!i_status.dec_zero) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.pop = 1'b1;
                    if (i_status.link_nil) begin
                        n_last  = 1'b1;
                        n_state = S_POP_EMIT;
                    end else begin
                        o_cmd.rd_sel = dltq_pkg::RD_LINKQ;
                        n_state      = S_POP_CHK;
                    end
                end
            end
            S_POP_RD: begin
                n_state = S_POP_HEAD;
            end
            S_POP_HEAD: begin
                // The head is known to have a zero delta here.
                o_cmd.pop = 1'b1;
                if (i_status.link_nil) begin
                    n_last  = 1'b1;
                    n_state = S_POP_EMIT;
                end else begin
                    o_cmd.rd_sel = dltq_pkg::RD_LINKQ;
                    n_state      = S_POP_CHK;
                end
            end
            S_POP_CHK: begin
                // The popped entry is the final one if its successor is not due.
                n_last  = i_status.delta_nz;
                n_state = S_POP_EMIT;
            end
            S_POP_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_exp  = 1'b1;
                    o_cmd.emit_last = r_last;
                    if (i_status.node_repeat) begin
                        o_cmd.rd_sel = dltq_pkg::RD_NODE;
                        n_state      = S_RELOAD_GO;
                    end else if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end
            end
            S_RELOAD_GO: begin
                o_cmd.reload_setup = 1'b1;
                n_state = i_status.head_nil ? S_LINK_FIN : S_LINK_WALK;
            end
            S_LINK_WALK: begin
                // Pass every entry whose delta fits in what is left.
                if (i_status.delta_le) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_status.link_nil) begin
                        n_state = S_LINK_FIN;
                    end else begin
                        o_cmd.rd_sel = dltq_pkg::RD_LINKQ;
                    end
                end else begin
                    o_cmd.walk_split = 1'b1;
                    n_state          = S_LINK_FIN;
                end
            end
            S_LINK_FIN: begin
                o_cmd.link_fin = 1'b1;
                if (i_status.prev_nil) begin
                    n_acc   = 1'b1;
                    n_state = done_state;
                end else begin
                    n_state = S_LINK_PREV;
                end
            end
            S_LINK_PREV: begin
                o_cmd.link_prev = 1'b1;
                n_acc           = 1'b1;
                n_state         = done_state;
            end
            S_UNL_WALK: begin
                if (i_status.node_is_t) begin
                    o_cmd.unl_found = 1'b1;
                    n_acc           = 1'b1;
                    if (i_status.link_nil) begin
                        n_state = S_RESP;
                    end else begin
                        o_cmd.rd_sel = dltq_pkg::RD_LINKQ;
                        n_state      = S_UNL_ADD;
                    end
                end else begin
                    o_cmd.unl_step = 1'b1;
                    o_cmd.rd_sel   = dltq_pkg::RD_LINKQ;
                end
            end
            S_UNL_ADD: begin
                // The successor takes over the removed entry's delta.
                o_cmd.unl_add = 1'b1;
                n_state       = S_RESP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= 1'b0;
            r_last    <= 1'b0;
            r_in_tick <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_last    <= n_last;
            r_in_tick <= n_in_tick;
        end
    end

endmodule
`default_nettype wire

>>> rtl/delta_list_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Software timers kept in one expiry-sorted list of deltas over the entry
// before; ticks pop due timers, starts insert in order, stops unlink.
//
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_ready   o_out_item (t_out_item)
//
// A start or a stop walks past the entries ahead of its place in the list, and
// each popped timer that repeats is put back in by an insert walk.
// The walk rate is set by the node memories: each step's read address is the
// link read in the cycle before. No clearing pass is needed after reset.
// A stalled result holds in the output register; the sequencer waits only
// when it has a further result to place there.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire dltq_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output dltq_pkg::t_out_item      o_out_item
);

    dltq_pkg::t_dp_cmd    cmd;
    dltq_pkg::t_dp_status status;

    // Sequencer.
    dltq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Node storage and list registers.
    dltq_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

>>> rtl/dltq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "delta_list_timer_queue_macros.svh"
// ----------------------------------------------------------------------------
// dltq_checker
// Port-level checks of the delta list timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dltq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire dltq_pkg::t_in_item  i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire dltq_pkg::t_out_item o_out_item
);

    // A stalled result transaction holds its value.
    `DLTQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // An expiry never reports a start or stop as taken.
    `DLTQ_ASSERT_IMPLY(a_exp_not_acc, i_clk, i_rst_n, o_out_valid && o_out_item.expired_valid, !o_out_item.accepted)

    // Only expiries can be followed by more results of the same input.
    `DLTQ_ASSERT_IMPLY(a_notlast_exp, i_clk, i_rst_n, o_out_valid && !o_out_item.last, o_out_item.expired_valid)

    // A result without an expiry carries a zero timer id.
    `DLTQ_ASSERT_IMPLY(a_id_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.expired_valid, o_out_item.expired_id == 4'd0)

    // One input transaction at a time: ready drops right after an accept.
    `DLTQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);
`default_nettype wire

>>> sim/dltq_expiry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_expiry_checker
// Watches both channels of the delta list timer queue and keeps its own
// delta-list model of the timers. Each input transaction yields the results
// it should cause, and each result transaction is compared field by field
// with the oldest one still waiting.
// ----------------------------------------------------------------------------
module dltq_expiry_checker #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire dltq_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire dltq_pkg::t_out_item i_out_item,
    output int                       o_mismatches,
    output int                       o_outstanding,
    output int                       o_results,
    output int                       o_expiries
);

    localparam int NIL = NUM_TIMERS;
    localparam int REPORT_LIMIT = 10;
    localparam int DW = dltq_pkg::DELTA_W;

    // Model state: one node per timer, linked in expiry order.
    logic [DW-1:0] delta_q  [NUM_TIMERS];
    logic [DW-1:0] reload_q [NUM_TIMERS];
    int            next_q   [NUM_TIMERS];
    bit            running_q[NUM_TIMERS];
    bit            rep_q    [NUM_TIMERS];
    int            head_q;

    // Results that the block still owes, oldest first.
    dltq_pkg::t_out_item due_results[$];

    // Clear the timer list and the bookkeeping.
    function automatic void clear_timers();
        for (int i = 0; i < NUM_TIMERS; i++) begin
            delta_q[i]   = '0;
            reload_q[i]  = '0;
            next_q[i]    = NIL;
            running_q[i] = 1'b0;
            rep_q[i]     = 1'b0;
        end
        head_q = NIL;
        due_results.delete();
    endfunction

    // Insert a timer behind every entry that expires no later than it does.
    function automatic void link_timer(int t, int ticks);
        int rem_ticks;
        int prev;
        int node;
        int steps;
        rem_ticks = (ticks == 0) ? 1 : ticks;
        prev      = NIL;
        node      = head_q;
        steps     = 0;
        while (node < NUM_TIMERS && steps < NUM_TIMERS &&
               int'(delta_q[node]) <= rem_ticks) begin
            rem_ticks -= int'(delta_q[node]);
            prev = node;
            node = next_q[node];
            steps++;
        end
        if (node < NUM_TIMERS) begin
            delta_q[node] = delta_q[node] - rem_ticks[DW-1:0];
        end else begin
            node = NIL;
        end
        delta_q[t] = rem_ticks[DW-1:0];
        next_q[t]  = node;
        if (prev < NUM_TIMERS) begin
            next_q[prev] = t;
        end else begin
            head_q = t;
        end
        running_q[t] = 1'b1;
    endfunction

    // Take a timer out of the list; its delta passes to the entry behind it.
    function automatic void unlink_timer(int t);
        int prev;
        int node;
        int steps;
        int after;
        prev  = NIL;
        node  = head_q;
        steps = 0;
        while (node < NUM_TIMERS && steps < NUM_TIMERS && node != t) begin
            prev = node;
            node = next_q[node];
            steps++;
        end
        if (node == t) begin
            after = next_q[t];
            if (after < NUM_TIMERS) begin
                delta_q[after] = delta_q[after] + delta_q[t];
            end else begin
                after = NIL;
            end
            if (prev < NUM_TIMERS) begin
                next_q[prev] = after;
            end else begin
                head_q = after;
            end
        end
    endfunction

    // Apply one input transaction to the model and queue its results.
    function automatic void predict_transaction(dltq_pkg::t_in_item item);
        int                  popped[$];
        int                  tid;
        int                  t;
        dltq_pkg::t_out_item res;
        tid = int'(item.tmr_sel);
        res = '0;
        res.last = 1'b1;
        case (item.op)
            dltq_pkg::OP_TICK: begin
                if (head_q < NUM_TIMERS) begin
                    if (delta_q[head_q] != 0) begin
                        delta_q[head_q] = delta_q[head_q] - 1'b1;
                    end
                    while (head_q < NUM_TIMERS && popped.size() < NUM_TIMERS &&
                           delta_q[head_q] == 0) begin
                        t = head_q;
                        head_q = next_q[t];
                        if (head_q >= NUM_TIMERS) begin
                            head_q = NIL;
                        end
                        next_q[t]    = NIL;
                        running_q[t] = 1'b0;
                        popped.push_back(t);
                    end
                end
                if (popped.size() == 0) begin
                    due_results.push_back(res);
                end else begin
                    // One expiry per popped timer, then repeat timers go back in.
                    foreach (popped[k]) begin
                        res.expired_valid = 1'b1;
                        res.expired_id    = popped[k][3:0];
                        res.accepted      = 1'b0;
                        res.last          = (k == popped.size() - 1);
                        due_results.push_back(res);
                    end
                    foreach (popped[k]) begin
                        if (rep_q[popped[k]]) begin
                            link_timer(popped[k], int'(reload_q[popped[k]]));
                        end
                    end
                end
            end
            dltq_pkg::OP_START: begin
                // A running timer ignores a second start.
                if (tid < NUM_TIMERS && !running_q[tid]) begin
                    rep_q[tid]    = item.repeat_req;
                    reload_q[tid] = (item.interval == '0) ? DW'(1) : item.interval;
                    link_timer(tid, int'(reload_q[tid]));
                    res.accepted  = 1'b1;
                end
                due_results.push_back(res);
            end
            dltq_pkg::OP_STOP: begin
                if (tid < NUM_TIMERS && running_q[tid]) begin
                    unlink_timer(tid);
                    running_q[tid] = 1'b0;
                    next_q[tid]    = NIL;
                    res.accepted   = 1'b1;
                end
                due_results.push_back(res);
            end
            default: begin
                // Unused op code: a single empty result.
                due_results.push_back(res);
            end
        endcase
    endfunction

    // Compare one result transaction with the oldest expectation.
    function automatic void check_result(dltq_pkg::t_out_item got);
        dltq_pkg::t_out_item want;
        if (due_results.size() == 0) begin
            if (o_mismatches < REPORT_LIMIT) begin
                $display("%0t: unexpected result exp_v=%0b id=%0d acc=%0b last=%0b",
                         $realtime, got.expired_valid, got.expired_id,
                         got.accepted, got.last);
            end
            o_mismatches++;
        end else begin
            want = due_results.pop_front();
            if (got.expired_valid !== want.expired_valid ||
                got.expired_id !== want.expired_id ||
                got.accepted !== want.accepted ||
                got.last !== want.last) begin
                if (o_mismatches < REPORT_LIMIT) begin
                    $display("%0t: result mismatch expected v=%0b id=%0d acc=%0b last=%0b",
                             $realtime, want.expired_valid, want.expired_id,
                             want.accepted, want.last);
                    $display("%0t:                 actual   v=%0b id=%0d acc=%0b last=%0b",
                             $realtime, got.expired_valid, got.expired_id,
                             got.accepted, got.last);
                end
                o_mismatches++;
            end
        end
        o_results++;
        if (got.expired_valid === 1'b1) begin
            o_expiries++;
        end
    endfunction

    // Sample both channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_timers();
            o_mismatches = 0;
            o_results    = 0;
            o_expiries   = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_transaction(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_item);
            end
        end
        o_outstanding = due_results.size();
    end

endmodule

>>> sim/tb_delta_list_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_list_timer_queue
// Drives starts, stops and ticks into the delta list timer queue: a directed
// opening, then random traffic in three idling phases, each with a burst
// that expires all sixteen timers on one tick. A separate checker predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_delta_list_timer_queue;

    localparam int         NUM_TIMERS   = 16;
    localparam logic [1:0] OP_RESERVED  = 2'd3;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 100;
    localparam int         PHASE_ITEMS  = 115;

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    dltq_pkg::t_in_item  in_item   = '0;
    logic                out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    dltq_pkg::t_out_item o_out_item;

    int mismatches;
    int outstanding;
    int results;
    int expiries;
    int n_sent        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    bit hold_served   = 1'b0;
    int hold_left     = 0;

    delta_list_timer_queue #(
        .NUM_TIMERS (NUM_TIMERS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    dltq_expiry_checker #(
        .NUM_TIMERS (NUM_TIMERS)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (o_out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_expiries    (expiries)
    );

    // 12 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, plus one long hold on request.
    always @(posedge i_clk) begin
        if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("tb_delta_list_timer_queue NOT OK");
        $finish;
    end

    // Offer one input transaction, idling first at the sender's rate.
    task automatic send_item(input logic [1:0] op, input logic [3:0] id,
                             input logic [15:0] ival, input logic rep);
        dltq_pkg::t_in_item item;
        item.op         = op;
        item.tmr_sel    = id;
        item.interval   = ival;
        item.repeat_req = rep;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
    endtask

    // Random traffic: mostly ticks and starts with short intervals.
    task automatic send_random_items(input int count);
        int          roll;
        int          pick;
        logic [15:0] ival;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            pick = $urandom_range(9);
            if (pick == 0) begin
                ival = 16'($urandom_range(65535));
            end else if (pick == 1) begin
                ival = '0;
            end else begin
                ival = 16'($urandom_range(12, 1));
            end
            if (roll < 38) begin
                send_item(dltq_pkg::OP_TICK, 4'($urandom_range(15)), ival,
                          1'($urandom_range(1)));
            end else if (roll < 73) begin
                send_item(dltq_pkg::OP_START, 4'($urandom_range(15)), ival,
                          1'($urandom_range(1)));
            end else if (roll < 95) begin
                send_item(dltq_pkg::OP_STOP, 4'($urandom_range(15)), ival,
                          1'($urandom_range(1)));
            end else begin
                send_item(OP_RESERVED, 4'($urandom_range(15)), ival,
                          1'($urandom_range(1)));
            end
        end
    endtask

    // Stop everything, start all timers due on the next tick, then tick.
    task automatic send_expiry_burst();
        for (int id = 0; id < NUM_TIMERS; id++) begin
            send_item(dltq_pkg::OP_STOP, 4'(id), 16'($urandom), 1'($urandom_range(1)));
        end
        for (int id = 0; id < NUM_TIMERS; id++) begin
            send_item(dltq_pkg::OP_START, 4'(id), 16'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
        repeat (3) send_item(dltq_pkg::OP_TICK, '0, '0, 1'b0);
    endtask

    // One idling phase: random traffic around an expiry burst.
    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        send_random_items(PHASE_ITEMS / 2);
        if (with_hold) begin
            hold_request = 1'b1;
        end
        send_expiry_burst();
        send_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
    endtask

    // Reset, directed cases, random phases, drain and verdict.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty tick, unused op code, stop of an idle timer.
        send_item(dltq_pkg::OP_TICK, 4'd0, 16'd0, 1'b0);
        send_item(OP_RESERVED, 4'd15, 16'hFFFF, 1'b1);
        send_item(dltq_pkg::OP_STOP, 4'd0, 16'd0, 1'b0);
        // A zero interval counts as one tick.
        send_item(dltq_pkg::OP_START, 4'd0, 16'd0, 1'b0);
        send_item(dltq_pkg::OP_TICK, 4'd0, 16'd0, 1'b0);
        // Longest interval; a second start is ignored, a second stop too.
        send_item(dltq_pkg::OP_START, 4'd15, 16'hFFFF, 1'b1);
        send_item(dltq_pkg::OP_START, 4'd15, 16'd5, 1'b0);
        send_item(dltq_pkg::OP_STOP, 4'd15, 16'd0, 1'b0);
        send_item(dltq_pkg::OP_STOP, 4'd15, 16'd0, 1'b0);
        // Equal expiries pop in start order; one of them repeats.
        send_item(dltq_pkg::OP_START, 4'd1, 16'd2, 1'b0);
        send_item(dltq_pkg::OP_START, 4'd2, 16'd2, 1'b1);
        send_item(dltq_pkg::OP_START, 4'd3, 16'd2, 1'b0);
        send_item(dltq_pkg::OP_START, 4'd4, 16'd1, 1'b0);
        send_item(dltq_pkg::OP_TICK, 4'd0, 16'd0, 1'b0);
        send_item(dltq_pkg::OP_TICK, 4'd0, 16'd0, 1'b0);
        // Stopping a timer hands its delta to the one behind it.
        send_item(dltq_pkg::OP_START, 4'd5, 16'd3, 1'b0);
        send_item(dltq_pkg::OP_STOP, 4'd2, 16'd0, 1'b0);
        repeat (3) send_item(dltq_pkg::OP_TICK, 4'd0, 16'd0, 1'b0);
        send_item(dltq_pkg::OP_START, 4'd6, 16'hFFFF, 1'b1);
        send_item(dltq_pkg::OP_STOP, 4'd6, 16'd0, 1'b0);

        run_phase(19, 50, 1'b1);
        run_phase(50, 19, 1'b0);
        run_phase(0, 0, 1'b0);
        in_valid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions (starts, stops, ticks, unused codes);",
                 n_sent);
        $display("checked %0d results, %0d expiries, %0d mismatches, one %0d-cycle hold.",
                 results, expiries, mismatches, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_delta_list_timer_queue OK");
        end else begin
            $display("tb_delta_list_timer_queue NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_datapath.sv
rtl/dltq_ctrl.sv
rtl/delta_list_timer_queue.sv
rtl/dltq_checker.sv
sim/dltq_expiry_checker.sv
sim/tb_delta_list_timer_queue.sv
